>>> rtl/lod_bias_governor_defines.svh
// ---------------------------------------------------------------------------
// lod_bias_governor_defines: shared assertion macros
// Checks on clk, quiet while rst is high.
// ---------------------------------------------------------------------------
`ifndef LOD_BIAS_GOVERNOR_DEFINES_SVH
`define LOD_BIAS_GOVERNOR_DEFINES_SVH

// condition must hold in the same cycle as the trigger
`define LBG_ASSERT_SAME(label, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
    else $error(msg);

// condition must hold in the cycle after the trigger
`define LBG_ASSERT_NEXT(label, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
    else $error(msg);

`endif

>>> rtl/lbg_pkg.sv
// ---------------------------------------------------------------------------
// lbg_pkg: types and constants of the lod bias governor
// Register map codes, nudge codes and field widths.
// ---------------------------------------------------------------------------
package lbg_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 16;
  localparam int BIAS_W     = 15;

  // register map
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TARGET_FREE_MB  = 3'd0,
    REG_BAND_MB         = 3'd1,
    REG_MEM_GAIN        = 3'd2,
    REG_STEP_LIMIT      = 3'd3,
    REG_TARGET_DENSITY  = 3'd4,
    REG_DENSITY_BAND    = 3'd5,
    REG_DENSITY_GAIN    = 3'd6,
    REG_GOVERNOR_ENABLE = 3'd7
  } cfg_reg_t;

  // manual nudge codes (two's complement 2 bit)
  localparam logic [1:0] NUDGE_UP   = 2'b01;
  localparam logic [1:0] NUDGE_DOWN = 2'b11;

  // 0.01 in Q3.12
  localparam logic signed [BIAS_W-1:0] NUDGE_LSB = 15'sd41;

  // largest per-update change: nudge + step limit + half step limit
  localparam int DELTA_MAX = 41 + 4095 + 2047;

endpackage

>>> rtl/lod_bias_governor.sv
// ---------------------------------------------------------------------------
// lod_bias_governor: texture lod bias governor
// Per-frame proportional control of a Q3.12 lod bias from free video memory
// and texel density, with manual nudge and output saturation.
// ---------------------------------------------------------------------------
//
//  channel   direction  handshake                      payload
//  s_axis    in         s_axis_tvalid / s_axis_tready  free_mb, avg_density, nudge; tuser vram_valid
//  m_axis    out        m_axis_tvalid / m_axis_tready  lod_bias
//  cfg       in         cfg_valid / cfg_ready          cfg_index, cfg_data
//
//  one request per cycle sustained while m_axis_tready keeps up; m_axis_tvalid
//  rises once a request has passed the input, multiply and step registers
//  and then loaded the bias register
//  the multiply stage sets the clock; the bias feedback loop is one add + clamp
//  rst clears all valid flags, the bias (to zero) and loads register defaults
//  each stage loads when empty or when the stage after it moves, so input
//  requests keep flowing into bubbles while a result waits on m_axis_tready
//  cfg_ready is always high; registers are meant to change while idle
//
`include "lod_bias_governor_defines.svh"

module lod_bias_governor #(
  parameter int BIAS_MIN = -1024,
  parameter int BIAS_MAX = 12288
) (
  input  logic                           clk,
  input  logic                           rst,
  // input stream
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // [15:0] free_mb, [31:16] avg_density, [33:32] manual_nudge, [39:34] zero
  input  logic [lbg_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // [0] vram_valid
  input  logic                           s_axis_tuser,
  // result stream
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [14:0] lod_bias, [15] zero
  output logic [lbg_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // register writes
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [lbg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lbg_pkg::CFG_DATA_W-1:0] cfg_data
);

  import lbg_pkg::*;

  localparam logic signed [15:0] SAT_MIN = 16'(BIAS_MIN);
  localparam logic signed [15:0] SAT_MAX = 16'(BIAS_MAX);

  // ------------------------------------------------------------------
  // configuration registers
  // ------------------------------------------------------------------
  logic [15:0] target_free_mb;
  logic [11:0] band_mb;
  logic [15:0] mem_gain;
  logic [11:0] step_limit;
  logic [15:0] target_density;
  logic [15:0] density_band;
  logic [15:0] density_gain;
  logic        governor_enable;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_free_mb  <= 16'd1024;
      band_mb         <= 12'd128;
      mem_gain        <= 16'd3670;
      step_limit      <= 12'd164;
      target_density  <= 16'd22938;
      density_band    <= 16'd1966;
      density_gain    <= 16'd61;
      governor_enable <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_TARGET_FREE_MB:  target_free_mb  <= cfg_data;
        REG_BAND_MB:         band_mb         <= cfg_data[11:0];
        REG_MEM_GAIN:        mem_gain        <= cfg_data;
        REG_STEP_LIMIT:      step_limit      <= cfg_data[11:0];
        REG_TARGET_DENSITY:  target_density  <= cfg_data;
        REG_DENSITY_BAND:    density_band    <= cfg_data;
        REG_DENSITY_GAIN:    density_gain    <= cfg_data;
        REG_GOVERNOR_ENABLE: governor_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // ------------------------------------------------------------------
  // pipeline flow control: a stage loads when empty or draining
  // ------------------------------------------------------------------
  logic v1, v2, v3;
  logic rdy1, rdy2, rdy3, rdy4;
  logic load4;

  assign rdy4  = !m_axis_tvalid || m_axis_tready;
  assign rdy3  = !v3 || rdy4;
  assign rdy2  = !v2 || rdy3;
  assign rdy1  = !v1 || rdy2;
  assign load4 = v3 && rdy4;

  assign s_axis_tready = rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1            <= 1'b0;
      v2            <= 1'b0;
      v3            <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (rdy1) v1 <= s_axis_tvalid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) m_axis_tvalid <= v3;
    end
  end

  // ------------------------------------------------------------------
  // stage 1: input register
  // ------------------------------------------------------------------
  logic [15:0] in_free_mb;
  logic        in_vram_valid;
  logic [15:0] in_avg_density;
  logic [1:0]  in_nudge;

  always_ff @(posedge clk) begin
    if (rdy1 && s_axis_tvalid) begin
      in_free_mb     <= s_axis_tdata[15:0];
      in_avg_density <= s_axis_tdata[31:16];
      in_nudge       <= s_axis_tdata[33:32];
      in_vram_valid  <= s_axis_tuser;
    end
  end

  // ------------------------------------------------------------------
  // stage 2: band tests and the two gain products
  // ------------------------------------------------------------------
  logic signed [17:0] band_low, band_high, free_s;
  logic               mem_below, mem_above;
  logic signed [17:0] mem_err_s;
  logic [16:0]        mem_err;
  logic [32:0]        mem_prod_next;
  logic signed [17:0] dens_err;
  logic [16:0]        dens_mag;
  logic signed [16:0] dens_gain_s;
  logic signed [33:0] dens_prod_next;

  always_comb begin
    free_s    = signed'({2'b00, in_free_mb});
    band_low  = signed'({2'b00, target_free_mb}) - signed'({6'd0, band_mb});
    band_high = signed'({2'b00, target_free_mb}) + signed'({6'd0, band_mb});
    mem_below = free_s < band_low;
    mem_above = free_s > band_high;
    mem_err_s = mem_below ? (band_low - free_s) : (free_s - band_high);
    mem_err   = mem_err_s[16:0];
    mem_prod_next = {17'd0, mem_gain} * {16'd0, mem_err};

    dens_err    = signed'({2'b00, in_avg_density}) - signed'({2'b00, target_density});
    dens_mag    = dens_err[17] ? 17'(-dens_err) : dens_err[16:0];
    dens_gain_s = signed'({1'b0, density_gain});
    dens_prod_next = dens_gain_s * dens_err;
  end

  logic               p_mem_up, p_mem_down, p_dens_on;
  logic [32:0]        p_mem_prod;
  logic signed [33:0] p_dens_prod;
  logic [1:0]         p_nudge;

  always_ff @(posedge clk) begin
    if (rdy2 && v1) begin
      p_mem_up    <= governor_enable && in_vram_valid && mem_below;
      p_mem_down  <= governor_enable && in_vram_valid && mem_above;
      p_dens_on   <= governor_enable && (dens_mag > {1'b0, density_band});
      p_mem_prod  <= mem_prod_next;
      p_dens_prod <= dens_prod_next;
      p_nudge     <= in_nudge;
    end
  end

  // ------------------------------------------------------------------
  // stage 3: scale, clamp and sum the per-frame change
  // ------------------------------------------------------------------
  logic [24:0]        mem_step_full;
  logic [11:0]        mem_step;
  logic signed [17:0] dens_step_full;
  logic signed [17:0] half_lim;
  logic signed [17:0] dens_step;
  logic signed [BIAS_W-1:0] nudge_delta, mem_delta, dens_delta;
  logic signed [BIAS_W-1:0] delta_next;

  always_comb begin
    mem_step_full = p_mem_prod[32:8];
    mem_step = (mem_step_full > {13'd0, step_limit}) ? step_limit : mem_step_full[11:0];

    // arithmetic shift gives floor division by 65536
    dens_step_full = p_dens_prod[33:16];
    half_lim = signed'({7'd0, step_limit[11:1]});
    if (dens_step_full > half_lim)
      dens_step = half_lim;
    else if (dens_step_full < -half_lim)
      dens_step = -half_lim;
    else
      dens_step = dens_step_full;

    case (p_nudge)
      NUDGE_UP:   nudge_delta = NUDGE_LSB;
      NUDGE_DOWN: nudge_delta = -NUDGE_LSB;
      default:    nudge_delta = '0;
    endcase

    if (p_mem_up)
      mem_delta = signed'({3'd0, mem_step});
    else if (p_mem_down)
      mem_delta = -signed'({3'd0, mem_step});
    else
      mem_delta = '0;

    dens_delta = p_dens_on ? dens_step[BIAS_W-1:0] : '0;
    delta_next = nudge_delta + mem_delta + dens_delta;
  end

  logic signed [BIAS_W-1:0] delta;

  always_ff @(posedge clk) begin
    if (rdy3 && v2) begin
      delta <= delta_next;
    end
  end

  // ------------------------------------------------------------------
  // stage 4: bias state, also the result register
  // ------------------------------------------------------------------
  logic signed [BIAS_W-1:0] bias;
  logic signed [15:0]       bias_sum;
  logic signed [BIAS_W-1:0] bias_next;

  always_comb begin
    bias_sum = signed'({bias[BIAS_W-1], bias}) + signed'({delta[BIAS_W-1], delta});
    if (bias_sum < SAT_MIN)
      bias_next = SAT_MIN[BIAS_W-1:0];
    else if (bias_sum > SAT_MAX)
      bias_next = SAT_MAX[BIAS_W-1:0];
    else
      bias_next = bias_sum[BIAS_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bias <= '0;
    end else if (load4) begin
      bias <= bias_next;
    end
  end

  assign m_axis_tdata = {1'b0, bias};

  // ------------------------------------------------------------------
  // checks
  // ------------------------------------------------------------------
  `LBG_ASSERT_SAME(a_bias_range, 1'b1, (bias >= SAT_MIN) && (bias <= SAT_MAX), "bias out of range")
  `LBG_ASSERT_NEXT(a_bias_hold, !rst && !load4, $stable(bias), "bias changed without a result load")
  `LBG_ASSERT_SAME(a_delta_bound, v3, (delta <= 15'(DELTA_MAX)) && (delta >= -15'(DELTA_MAX)), "per-frame change out of bound")
  `LBG_ASSERT_SAME(a_full_stall, m_axis_tvalid && !m_axis_tready && v1 && v2 && v3, !s_axis_tready, "input taken into a full stalled pipeline")

endmodule
